// ----- design/gzhs_pkg.sv -----
// gzhs_pkg: types, codes and helpers shared by the gzip header stripper.
// No dependencies; used by gzhs_parser and gzip_header_stripper.

package gzhs_pkg;

	typedef enum logic [3:0] {
		PH_FIXED   = 4'd0,
		PH_XLO     = 4'd1,
		PH_XHI     = 4'd2,
		PH_XDATA   = 4'd3,
		PH_NAME    = 4'd4,
		PH_COMMENT = 4'd5,
		PH_HCRC    = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_DROP    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_BAD_HDR = 2'd1,
		KIND_TRUNC   = 2'd2
	} kind_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] payload;
		logic       end_mark;
	} result_t;

	localparam logic [7:0]  FL_HCRC        = 8'h02;
	localparam logic [7:0]  FL_EXTRA       = 8'h04;
	localparam logic [7:0]  FL_NAME        = 8'h08;
	localparam logic [7:0]  FL_COMMENT     = 8'h10;
	localparam logic [7:0]  FL_RESV        = 8'he0;
	localparam logic [15:0] FIXED_LEN      = 16'd10;
	localparam logic [15:0] METHOD_POS     = 16'd2;
	localparam logic [15:0] FLAGS_POS      = 16'd3;
	localparam logic [15:0] HCRC_LEN       = 16'd2;
	localparam logic [7:0]  METHOD_DEFLATE = 8'd8;

	// First optional section at or after 'from' that the flags select.
	function automatic phase_t enter_section(input phase_t from, input logic [7:0] flags);
		phase_t ph;
		ph = PH_PAYLOAD;
		if (from <= PH_HCRC && (flags & FL_HCRC) != 8'd0)
			ph = PH_HCRC;
		if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'd0)
			ph = PH_COMMENT;
		if (from <= PH_NAME && (flags & FL_NAME) != 8'd0)
			ph = PH_NAME;
		if (from <= PH_XLO && (flags & FL_EXTRA) != 8'd0)
			ph = PH_XLO;
		return ph;
	endfunction

endpackage

// ----- design/gzip_header_stripper.sv -----
// gzip_header_stripper: top level; input register, parser, result register.
// Depends on gzhs_pkg and gzhs_parser.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-----------------------------
//   input     | in_valid / in_ready   | in_byte, in_last
//   result    | out_valid / out_ready | kind, payload, end_mark
//
// One byte per cycle when results are taken; input register, parser, result register.
// The phase update is one step of the parser between the input and result registers.
// A byte that gives no result still waits for a free result register to advance.
// Reset (arst_n low) returns to the fixed header phase and empties both registers.
// A stalled result only holds off the input once the input register is also full.

module gzip_header_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] payload,
	output logic       end_mark
);

	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              adv;
	gzhs_pkg::result_t res;
	logic              out_valid_q;
	gzhs_pkg::kind_t   kind_q;
	logic [7:0]        payload_q;
	logic              end_mark_q;

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	gzhs_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (adv),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			kind_q     <= res.kind;
			payload_q  <= res.payload;
			end_mark_q <= res.end_mark;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign payload   = payload_q;
	assign end_mark  = end_mark_q;

endmodule

// ----- design/gzhs_parser.sv -----
// gzhs_parser: header phase state and the per-byte step logic.
// Depends on gzhs_pkg. Produces at most one result per advanced byte.

module gzhs_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output gzhs_pkg::result_t res
);

	gzhs_pkg::phase_t phase_q, phase_n;
	logic [15:0]      cnt_q, cnt_n;
	logic [7:0]       flags_q, flags_n;
	logic [7:0]       xlo_q, xlo_n;
	logic             err;
	logic             in_hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gzhs_pkg::PH_FIXED;
			cnt_q   <= 16'd0;
			flags_q <= 8'd0;
			xlo_q   <= 8'd0;
		end else if (go) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			flags_q <= flags_n;
			xlo_q   <= xlo_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		flags_n = flags_q;
		xlo_n   = xlo_q;
		err     = 1'b0;
		in_hdr  = (phase_q != gzhs_pkg::PH_PAYLOAD) && (phase_q != gzhs_pkg::PH_DROP);
		res     = '{valid: 1'b0, kind: gzhs_pkg::KIND_PAYLOAD, payload: 8'd0,
			end_mark: in_last};

		case (phase_q)
			gzhs_pkg::PH_PAYLOAD: begin
				res.valid   = 1'b1;
				res.payload = in_byte;
			end
			gzhs_pkg::PH_DROP: begin
				res.valid = 1'b0;
			end
			gzhs_pkg::PH_FIXED: begin
				if (cnt_q == gzhs_pkg::METHOD_POS && in_byte != gzhs_pkg::METHOD_DEFLATE) begin
					err = 1'b1;
				end else begin
					if (cnt_q == gzhs_pkg::FLAGS_POS) begin
						flags_n = in_byte;
						err     = (in_byte & gzhs_pkg::FL_RESV) != 8'd0;
					end
					cnt_n = 16'(cnt_q + 16'd1);
					if (cnt_n >= gzhs_pkg::FIXED_LEN)
						phase_n = gzhs_pkg::enter_section(gzhs_pkg::PH_XLO, flags_n);
				end
			end
			gzhs_pkg::PH_XLO: begin
				xlo_n   = in_byte;
				phase_n = gzhs_pkg::PH_XHI;
			end
			gzhs_pkg::PH_XHI: begin
				cnt_n = {in_byte, xlo_q};
				if (cnt_n == 16'd0)
					phase_n = gzhs_pkg::enter_section(gzhs_pkg::PH_NAME, flags_q);
				else
					phase_n = gzhs_pkg::PH_XDATA;
			end
			gzhs_pkg::PH_XDATA: begin
				cnt_n = 16'(cnt_q - 16'd1);
				if (cnt_n == 16'd0)
					phase_n = gzhs_pkg::enter_section(gzhs_pkg::PH_NAME, flags_q);
			end
			gzhs_pkg::PH_NAME: begin
				if (in_byte == 8'd0)
					phase_n = gzhs_pkg::enter_section(gzhs_pkg::PH_COMMENT, flags_q);
			end
			gzhs_pkg::PH_COMMENT: begin
				if (in_byte == 8'd0)
					phase_n = gzhs_pkg::enter_section(gzhs_pkg::PH_HCRC, flags_q);
			end
			gzhs_pkg::PH_HCRC: begin
				cnt_n = 16'(cnt_q + 16'd1);
				if (cnt_n >= gzhs_pkg::HCRC_LEN)
					phase_n = gzhs_pkg::PH_PAYLOAD;
			end
			default: begin
				phase_n = gzhs_pkg::PH_DROP;
			end
		endcase

		// CRC bytes are counted from zero on entry
		if (phase_n == gzhs_pkg::PH_HCRC && phase_q != gzhs_pkg::PH_HCRC)
			cnt_n = 16'd0;

		if (in_hdr && err) begin
			res.valid = 1'b1;
			res.kind  = gzhs_pkg::KIND_BAD_HDR;
			phase_n   = gzhs_pkg::PH_DROP;
		end else if (in_hdr && in_last) begin
			// stream ended inside the header, even on its final byte
			res.valid = 1'b1;
			res.kind  = gzhs_pkg::KIND_TRUNC;
		end

		if (in_last) begin
			phase_n = gzhs_pkg::PH_FIXED;
			cnt_n   = 16'd0;
			flags_n = 8'd0;
			xlo_n   = 8'd0;
		end
	end

	a_bad_drops: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.valid && res.kind == gzhs_pkg::KIND_BAD_HDR && !in_last
		|=> phase_q == gzhs_pkg::PH_DROP)
		else $error("bad header did not enter drop phase");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		go && in_last |=> phase_q == gzhs_pkg::PH_FIXED && cnt_q == 16'd0 && flags_q == 8'd0)
		else $error("state not cleared after last byte");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == gzhs_pkg::PH_DROP |-> !res.valid)
		else $error("result produced while dropping");

	a_payload_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind != gzhs_pkg::KIND_PAYLOAD |-> res.payload == 8'd0)
		else $error("non-zero payload on error result");

endmodule
